// File: sv/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg: shared types and constants
// Operation kinds, register indexes and the records that travel down the
// displacement pipeline and the square root cell chain.
// ----------------------------------------------------------------------------
package pcd_pkg;

	localparam int NUM_DIM_DEF = 3;
	localparam int MAX_DIM = 3;
	localparam int ROOT_CELLS = 32;

	typedef enum logic [1:0] {
		KIND_SUB  = 2'd0,
		KIND_ADD  = 2'd1,
		KIND_DIST = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_MASK    = 3'd0,
		REG_SPAN_X  = 3'd1,
		REG_SPAN_Y  = 3'd2,
		REG_SPAN_Z  = 3'd3,
		REG_START_X = 3'd4,
		REG_START_Y = 3'd5,
		REG_START_Z = 3'd6,
		REG_NONE    = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic [MAX_DIM-1:0][31:0] res;
		logic                     oor;
		logic                     is_dist;
	} pay_t;

	typedef struct packed {
		logic [63:0] rad;
		logic [34:0] rem;
		logic [31:0] root;
		pay_t        pay;
	} root_t;

endpackage

// File: sv/periodic_coordinate_difference.sv
// ----------------------------------------------------------------------------
// periodic_coordinate_difference: minimum-image displacement unit
// Subtracts, adds or measures the distance between two Q16.16 points on a
// box with optionally periodic axes.
//
// An input beat carries kind and both points on in_valid/in_ready; a result
// beat carries res_x/y/z, dist_res and out_of_range on out_valid/out_ready.
// Registers are written through cfg_we, cfg_index and cfg_wdata and must
// only change while no beat is in flight.
// One beat is accepted per cycle while in_ready is high. The accepting
// edge loads the input register; then come the axis fold and limit stage,
// squaring, sum of squares, 32 square root cells (one root bit each) and
// the output register, which drives out_valid.
// The whole pipeline advances together; when the receiver holds out_ready
// low with a result waiting, in_ready drops and every stage holds.
// Reset clears the configuration registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module periodic_coordinate_difference import pcd_pkg::*; #(
	parameter int NUM_DIM = NUM_DIM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [31:0] a_x,
	input  logic [31:0] a_y,
	input  logic [31:0] a_z,
	input  logic [31:0] b_x,
	input  logic [31:0] b_y,
	input  logic [31:0] b_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] res_x,
	output logic [31:0] res_y,
	output logic [31:0] res_z,
	output logic [31:0] dist_res,
	output logic        out_of_range
);

	logic [2:0]               periodic_mask_q;
	logic [MAX_DIM-1:0][30:0] span_q;
	logic [MAX_DIM-1:0][31:0] start_q;

	logic                     en;
	logic                     v_s1, v_s2, v_s3, v_s4;
	kind_t                    kind_s1, kind_s2, kind_s3, kind_s4;
	logic [MAX_DIM-1:0][31:0] a_s1, b_s1, res_s2, res_s3, res_s4;
	logic [MAX_DIM-1:0]       oor_s2;
	logic                     oor_s3, oor_s4;
	logic [MAX_DIM-1:0][63:0] sq_s3;
	logic [63:0]              sum_s4;

	logic  [ROOT_CELLS:0] cell_v;
	root_t                cell_d [ROOT_CELLS+1];
	root_t                last;

	assign en = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			periodic_mask_q <= '0;
			span_q <= '0;
			start_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_MASK:    periodic_mask_q <= cfg_wdata[2:0];
				REG_SPAN_X:  span_q[0] <= cfg_wdata[30:0];
				REG_SPAN_Y:  span_q[1] <= cfg_wdata[30:0];
				REG_SPAN_Z:  span_q[2] <= cfg_wdata[30:0];
				REG_START_X: start_q[0] <= cfg_wdata;
				REG_START_Y: start_q[1] <= cfg_wdata;
				REG_START_Z: start_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind_t'(kind);
			a_s1 <= {a_z, a_y, a_x};
			b_s1 <= {b_z, b_y, b_x};
			kind_s2 <= kind_s1;
		end
	end

	for (genvar d = 0; d < MAX_DIM; d++) begin : g_axis
		pcd_axis u_axis (
			.clk      (clk),
			.en       (en),
			.kind     (kind_s1),
			.active   (d < NUM_DIM),
			.periodic (periodic_mask_q[d]),
			.span     (span_q[d]),
			.start    (start_q[d]),
			.a        (a_s1[d]),
			.b        (b_s1[d]),
			.res_s2   (res_s2[d]),
			.oor_s2   (oor_s2[d])
		);

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s3[d] <= (res_s2[d][31] ? 32'(-res_s2[d]) : res_s2[d])
					* (res_s2[d][31] ? 32'(-res_s2[d]) : res_s2[d]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= res_s2;
			oor_s3 <= |oor_s2;
			kind_s3 <= kind_s2;
			res_s4 <= res_s3;
			oor_s4 <= oor_s3;
			kind_s4 <= kind_s3;
			sum_s4 <= sq_s3[0] + sq_s3[1] + sq_s3[2];
		end
	end

	always_comb begin
		cell_v[0] = v_s4;
		cell_d[0].rad = sum_s4;
		cell_d[0].rem = '0;
		cell_d[0].root = '0;
		cell_d[0].pay.res = res_s4;
		cell_d[0].pay.oor = oor_s4;
		cell_d[0].pay.is_dist = kind_s4 == KIND_DIST;
	end

	for (genvar c = 0; c < ROOT_CELLS; c++) begin : g_cell
		pcd_root_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (cell_v[c]),
			.data_in  (cell_d[c]),
			.valid_q  (cell_v[c+1]),
			.data_q   (cell_d[c+1])
		);
	end

	assign last = cell_d[ROOT_CELLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= cell_v[ROOT_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_x <= last.pay.res[0];
			res_y <= last.pay.res[1];
			res_z <= last.pay.res[2];
			dist_res <= last.pay.is_dist ? last.root : '0;
			out_of_range <= last.pay.oor;
		end
	end

endmodule

// File: sv/pcd_axis.sv
// ----------------------------------------------------------------------------
// pcd_axis: one axis of the displacement stage
// Forms the folded difference or the wrapped sum of one coordinate pair,
// saturates it to 32 bits and raises the limit flag.
// ----------------------------------------------------------------------------
module pcd_axis import pcd_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  kind_t       kind,
	input  logic        active,
	input  logic        periodic,
	input  logic [30:0] span,
	input  logic [31:0] start,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] res_s2,
	output logic        oor_s2
);

	localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
	localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

	logic signed [33:0] sa, sb, sspan, lo, hi;
	logic signed [33:0] diff, t1, t2, fold, mag, sum, wrap, r;
	logic               sub_flag, add_flag, lim_flag;
	logic [31:0]        res_d;
	logic               oor_d;

	always_comb begin
		sa = {{2{a[31]}}, a};
		sb = {{2{b[31]}}, b};
		sspan = {3'b000, span};
		lo = {{2{start[31]}}, start};
		hi = lo + sspan;

		diff = sa - sb;
		t1 = (diff < 0) ? -diff : diff;
		t2 = sspan - t1;
		fold = diff;
		if (periodic && (t1 > t2)) begin
			fold = (diff > 0) ? -t2 : t2;
		end
		mag = (fold < 0) ? -fold : fold;
		sub_flag = mag > sspan;

		sum = sa + sb;
		wrap = sum;
		if (sum < lo) begin
			if (periodic) wrap = sum + sspan;
		end else if (sum > hi) begin
			if (periodic) wrap = sum - sspan;
		end
		add_flag = (wrap < lo) || (wrap > hi);

		if (kind == KIND_ADD) begin
			r = wrap;
			lim_flag = add_flag;
		end else begin
			r = fold;
			lim_flag = sub_flag;
		end

		res_d = r[31:0];
		oor_d = lim_flag;
		if (r > SAT_MAX) begin
			res_d = 32'h7fff_ffff;
			oor_d = 1'b1;
		end else if (r < SAT_MIN) begin
			res_d = 32'h8000_0000;
			oor_d = 1'b1;
		end
		if (!active || kind == KIND_NONE) begin
			res_d = '0;
			oor_d = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2 <= res_d;
			oor_s2 <= oor_d;
		end
	end

endmodule

// File: sv/pcd_root_cell.sv
// ----------------------------------------------------------------------------
// pcd_root_cell: one step of the integer square root chain
// Brings in two radicand bits, tries the next root bit and hands the
// remainder, partial root and the result record to the next cell.
// ----------------------------------------------------------------------------
module pcd_root_cell import pcd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  valid_in,
	input  root_t data_in,
	output logic  valid_q,
	output root_t data_q
);

	logic [34:0] rem_sh, trial;
	root_t       nxt;

	always_comb begin
		nxt = data_in;
		rem_sh = {data_in.rem[32:0], data_in.rad[63:62]};
		trial = {1'b0, data_in.root, 2'b01};
		nxt.rad = {data_in.rad[61:0], 2'b00};
		if (rem_sh >= trial) begin
			nxt.rem = rem_sh - trial;
			nxt.root = {data_in.root[30:0], 1'b1};
		end else begin
			nxt.rem = rem_sh;
			nxt.root = {data_in.root[30:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

endmodule
